// ===== hdl/bsc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Block store CRC package
// Shared constants, codes, state type and the byte-wide CRC-8 step.
// ----------------------------------------------------------------------------
package bsc_pkg;

   localparam int PAK_BYTES     = 32768;
   localparam int BLOCK_BYTES   = 32;
   localparam int WORD_BITS     = 64;
   localparam int WORD_BYTES    = WORD_BITS / 8;
   localparam int PAK_WORDS     = PAK_BYTES / WORD_BYTES;
   localparam int BLOCK_WORDS   = BLOCK_BYTES / WORD_BYTES;
   localparam int MEM_ADDR_BITS = $clog2(PAK_WORDS);
   localparam int WIDX_BITS     = $clog2(BLOCK_WORDS);
   localparam int BLK_BITS      = MEM_ADDR_BITS - WIDX_BITS;
   localparam int BLK_LSB       = $clog2(BLOCK_BYTES);
   localparam int BYTE_IDX_BITS = $clog2(WORD_BYTES);
   localparam int ADDR_BITS     = 16;
   localparam int CRC_BITS      = 8;

   localparam int REQ_DATA_BITS = 88;
   localparam int RSP_DATA_BITS = 80;
   localparam int RSP_PAD_BITS  = RSP_DATA_BITS - WORD_BITS - WIDX_BITS - CRC_BITS;

   localparam logic [CRC_BITS-1:0]      CRC_POLY  = 8'h85;
   localparam logic [WIDX_BITS-1:0]     LAST_WORD = WIDX_BITS'(BLOCK_WORDS - 1);
   localparam logic [BYTE_IDX_BITS-1:0] LAST_BYTE = BYTE_IDX_BITS'(WORD_BYTES - 1);

   localparam logic CMD_READ   = 1'b0;
   localparam logic CMD_WRITE  = 1'b1;
   localparam logic KIND_READ  = 1'b0;
   localparam logic KIND_WRITE = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_LOAD,
      ST_CRC,
      ST_AUG,
      ST_EMIT
   } state_type;

   function automatic logic [CRC_BITS-1:0] crc_byte(input logic [CRC_BITS-1:0] crc,
                                                    input logic [7:0] data);
      logic [CRC_BITS-1:0] c;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         c = {c[CRC_BITS-2:0], data[i]} ^ (c[CRC_BITS-1] ? CRC_POLY : '0);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/block_store_with_crc8_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Block store with CRC-8
// 32 KiB store of 64-bit words, accessed in 32-byte blocks, CRC-8 (0x85).
// ----------------------------------------------------------------------------
// After reset the store runs a clearing pass over all 4096 words, one word a
// cycle, with req_tready low. A read request (tuser 0) returns the four words
// of the block picked by address bits 14..5, first byte in the top bits; the
// fourth carries tlast and the augmented CRC-8 of the block. A write request
// (tuser 1) stores one word; the write of word 3 then returns one completion
// with the CRC of the block as stored. The CRC runs one byte per cycle. A read
// steps through fetch, load, eight byte steps and hand-off for each word, with
// one more step for the trailing zero byte before the last hand-off; a write
// of word 3 does the same but hands off only after the last word. A result
// held in the output register does not block the next request.
// ----------------------------------------------------------------------------
module block_store_with_crc8_unit
   import bsc_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   // address[15:0], word_index[17:16], write_word[81:18], zero[87:82]
   input  wire logic [REQ_DATA_BITS-1:0] req_tdata,
   // command[0]
   input  wire logic                     req_tuser,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   // read_word[63:0], read_index[65:64], block_crc[73:66], zero[79:74]
   output logic      [RSP_DATA_BITS-1:0] rsp_tdata,
   // result_kind[0]
   output logic                          rsp_tuser,
   output logic                          rsp_tlast
);

   state_type state_ff, state_in;

   logic [MEM_ADDR_BITS-1:0] clr_ff, clr_in;
   logic [BLK_BITS-1:0]      blk_ff, blk_in;
   logic [WIDX_BITS-1:0]     k_ff, k_in;
   logic [BYTE_IDX_BITS-1:0] byte_ff, byte_in;
   logic                     kind_ff, kind_in;
   logic [WORD_BITS-1:0]     word_ff, word_in;
   logic [CRC_BITS-1:0]      crc_ff, crc_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic                     rsp_user_ff, rsp_user_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic [ADDR_BITS-1:0]     req_address;
   logic [WIDX_BITS-1:0]     req_widx;
   logic [WORD_BITS-1:0]     req_word;
   logic                     req_fire;
   logic                     rsp_free;
   logic                     start;

   logic                     ram_wr_en;
   logic [MEM_ADDR_BITS-1:0] ram_wr_addr;
   logic [WORD_BITS-1:0]     ram_wr_data;
   logic                     ram_rd_en;
   logic [WORD_BITS-1:0]     ram_rd_data;
   logic [7:0]               cur_byte;

   assign req_address = req_tdata[ADDR_BITS-1:0];
   assign req_widx    = req_tdata[ADDR_BITS +: WIDX_BITS];
   assign req_word    = req_tdata[ADDR_BITS+WIDX_BITS +: WORD_BITS];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign start      = req_fire && ((req_tuser == CMD_READ) || (req_widx == LAST_WORD));
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign cur_byte   = word_ff[{~byte_ff, 3'b000} +: 8];

   bsc_ram #(
      .WIDTH(WORD_BITS),
      .DEPTH(PAK_WORDS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr ({blk_ff, k_ff}),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == '1) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) state_in = ST_FETCH;
         end
         ST_FETCH: state_in = ST_LOAD;
         ST_LOAD:  state_in = ST_CRC;
         ST_CRC: begin
            if (byte_ff == LAST_BYTE) begin
               if (k_ff == LAST_WORD)       state_in = ST_AUG;
               else if (kind_ff == KIND_READ) state_in = ST_EMIT;
               else                          state_in = ST_FETCH;
            end
         end
         ST_AUG:   state_in = ST_EMIT;
         ST_EMIT: begin
            if (rsp_free) state_in = (k_ff == LAST_WORD) ? ST_IDLE : ST_FETCH;
         end
         default:  state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      clr_in       = clr_ff;
      blk_in       = blk_ff;
      k_in         = k_ff;
      byte_in      = byte_ff;
      kind_in      = kind_ff;
      word_in      = word_ff;
      crc_in       = crc_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = clr_ff;
      ram_wr_data  = '0;
      ram_rd_en    = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en = 1'b1;
            clr_in    = clr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (req_fire && (req_tuser == CMD_WRITE)) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = {req_address[BLK_LSB +: BLK_BITS], req_widx};
               ram_wr_data = req_word;
            end
            if (start) begin
               blk_in  = req_address[BLK_LSB +: BLK_BITS];
               kind_in = req_tuser;
               k_in    = '0;
               crc_in  = '0;
            end
         end
         ST_FETCH: ram_rd_en = 1'b1;
         ST_LOAD: begin
            word_in = ram_rd_data;
            byte_in = '0;
         end
         ST_CRC: begin
            crc_in  = crc_byte(crc_ff, cur_byte);
            byte_in = byte_ff + 1'b1;
            if ((byte_ff == LAST_BYTE) && (k_ff != LAST_WORD) && (kind_ff == KIND_WRITE)) begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_AUG:   crc_in = crc_byte(crc_ff, 8'h00);
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = kind_ff;
               rsp_last_in  = (k_ff == LAST_WORD);
               rsp_data_in  = {RSP_PAD_BITS'(0),
                               (k_ff == LAST_WORD) ? crc_ff : CRC_BITS'(0),
                               (kind_ff == KIND_READ) ? k_ff : WIDX_BITS'(0),
                               (kind_ff == KIND_READ) ? word_ff : WORD_BITS'(0)};
               if (k_ff != LAST_WORD) k_in = k_ff + 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         k_ff         <= '0;
         byte_ff      <= '0;
         kind_ff      <= KIND_READ;
         crc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         k_ff         <= k_in;
         byte_ff      <= byte_in;
         kind_ff      <= kind_in;
         crc_ff       <= crc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff      <= blk_in;
      word_ff     <= word_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
`default_nettype wire

// ===== hdl/bsc_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module bsc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== hdl/bsc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Block store checker
// Port-level checks on reset quiet and response framing, bound to the top level.
// ----------------------------------------------------------------------------
module bsc_checker
   import bsc_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_tready,
   input wire logic                     rsp_tvalid,
   input wire logic                     rsp_tready,
   input wire logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input wire logic                     rsp_tuser,
   input wire logic                     rsp_tlast
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_tvalid && !req_tready)
      else $error("response or ready active right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled response changed");

   a_read_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_READ) |->
         rsp_tlast == (rsp_tdata[WORD_BITS +: WIDX_BITS] == LAST_WORD))
      else $error("read tlast not on the last word");

   a_write_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_WRITE) |->
         rsp_tlast && (rsp_tdata[WORD_BITS+WIDX_BITS-1:0] == '0))
      else $error("write completion malformed");

   a_crc_only_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> (rsp_tdata[WORD_BITS+WIDX_BITS +: CRC_BITS] == '0))
      else $error("crc present on a non-final response");

endmodule

bind block_store_with_crc8_unit bsc_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire
